// ===== rtl/rsp_pkg.sv =====
// Shared types for the ramp-and-soak profile sequencer.
// No dependencies; used by the top level and its checker.
package rsp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAITING  = 2'd1,
    PH_COOKING  = 2'd2,
    PH_FINISHED = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START_NOW = 3'd1,
    OP_START_AT  = 3'd2,
    OP_START_BY  = 3'd3,
    OP_NEXT      = 3'd4,
    OP_ABORT     = 3'd5,
    OP_WRITE     = 3'd6,
    OP_NONE      = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_APPLY,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam int TEMP_W = 12;
  localparam int TIME_W = 32;
  localparam int NUM_W  = TEMP_W + TIME_W;

endpackage

// ===== rtl/ramp_soak_profile_sequencer.sv =====
// Ramp-and-soak setpoint programmer: recipe memory, step walk and serial divider.
// Depends on rsp_pkg.
//
// Each item walks the recipe memory, one read and one evaluation per step, then applies
// its opcode; when a tick lands inside a ramp step, a multiply and the bit-per-cycle
// serial divider follow before the result is registered.
// The recipe memory holds RECIPES*STEPS entries with a valid bit each, so it reads as zero
// right after reset with no clearing pass. One item is in work at a time; its result waits
// in an output register while the next item may already be accepted.
module ramp_soak_profile_sequencer #(
  parameter int RECIPES = 4,
  parameter int STEPS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] now_seconds,
  input  logic [1:0]  recipe_index,
  input  logic [2:0]  step_index,
  input  logic [31:0] step_duration,
  input  logic [11:0] step_temperature,
  input  logic [31:0] target_time,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [11:0] setpoint,
  output logic        released,
  output logic [1:0]  phase,
  output logic [31:0] remaining_seconds
);

  localparam int ENTRIES = RECIPES * STEPS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCW     = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DCW     = $clog2(rsp_pkg::NUM_W);
  localparam int MW      = rsp_pkg::TEMP_W + rsp_pkg::TIME_W;

  rsp_pkg::state_t state, state_next;

  logic [MW-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] mem_vld;
  logic [MW-1:0]  rdata;
  logic           rvld;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           wr_en;

  rsp_pkg::opcode_t op;
  logic [31:0] now_q, tgt_q, dur_q;
  logic [1:0]  rec_q, run_rec;
  logic [2:0]  stp_q;
  logic [11:0] tmp_q;

  rsp_pkg::phase_t ph;
  logic [1:0]  active_recipe;
  logic [31:0] start_time;

  logic [SCW-1:0] idx;
  logic [31:0] total, el0, e, pd, de, dd, wold;
  logic [11:0] pt, tf, t0, t1;
  logic        found, fdiv, sp_en;
  logic [rsp_pkg::NUM_W-1:0] num;
  logic [31:0] rem;
  logic [DCW-1:0] dcnt;

  logic rec_ok, stp_ok, can_arm, last_step;
  logic [31:0] d_rd, es, rd_full, wr_full;
  logic [11:0] t_rd, mag, q12, ramp_val;
  logic [32:0] rem_sh;
  logic        neg;

  assign rec_ok    = {30'd0, rec_q} < 32'(RECIPES);
  assign stp_ok    = {29'd0, stp_q} < 32'(STEPS);
  assign can_arm   = (ph == rsp_pkg::PH_IDLE) || (ph == rsp_pkg::PH_WAITING);
  assign last_step = 32'(idx) == 32'(STEPS - 1);
  assign d_rd      = rvld ? rdata[31:0] : 32'd0;
  assign t_rd      = rvld ? rdata[MW-1:32] : 12'd0;
  assign es        = e - pd;
  assign rd_full   = 32'(run_rec) * 32'(STEPS) + 32'(idx);
  assign wr_full   = 32'(rec_q) * 32'(STEPS) + 32'(stp_q);
  assign neg       = t1 < t0;
  assign mag       = neg ? (t0 - t1) : (t1 - t0);
  assign rem_sh    = {rem, num[rsp_pkg::NUM_W-1]};
  assign q12       = num[11:0];
  assign ramp_val  = !found ? 12'd0 : (!fdiv ? tf : (neg ? (t0 - q12) : (t0 + q12)));

  always_comb begin
    state_next = state;
    case (state)
      rsp_pkg::ST_IDLE:  if (item_valid) state_next = rsp_pkg::ST_RD;
      rsp_pkg::ST_RD:    state_next = rsp_pkg::ST_EV;
      rsp_pkg::ST_EV:    state_next = last_step ? rsp_pkg::ST_APPLY : rsp_pkg::ST_RD;
      rsp_pkg::ST_APPLY: begin
        if (op == rsp_pkg::OP_TICK && ph == rsp_pkg::PH_COOKING && found && fdiv)
          state_next = rsp_pkg::ST_MUL;
        else
          state_next = rsp_pkg::ST_OUT;
      end
      rsp_pkg::ST_MUL:   state_next = rsp_pkg::ST_DIV;
      rsp_pkg::ST_DIV: begin
        if (32'(dcnt) == 32'(rsp_pkg::NUM_W - 1)) state_next = rsp_pkg::ST_OUT;
      end
      rsp_pkg::ST_OUT:   if (!result_valid || result_ready) state_next = rsp_pkg::ST_IDLE;
      default:           state_next = rsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = state == rsp_pkg::ST_IDLE;
    rd_addr    = rd_full[AW-1:0];
    wr_addr    = wr_full[AW-1:0];
    wr_en      = (state == rsp_pkg::ST_APPLY) && (op == rsp_pkg::OP_WRITE) && rec_ok && stp_ok;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {tmp_q, dur_q};
    if (state == rsp_pkg::ST_RD) begin
      rdata <= mem[rd_addr];
      rvld  <= mem_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rsp_pkg::ST_IDLE;
      mem_vld       <= '0;
      ph            <= rsp_pkg::PH_IDLE;
      active_recipe <= 2'd0;
      start_time    <= 32'd0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (result_valid && result_ready && state != rsp_pkg::ST_OUT) result_valid <= 1'b0;
      case (state)
        rsp_pkg::ST_IDLE: begin
          if (item_valid) begin
            op    <= rsp_pkg::opcode_t'(opcode);
            now_q <= now_seconds;
            tgt_q <= target_time;
            dur_q <= step_duration;
            rec_q <= recipe_index;
            stp_q <= step_index;
            tmp_q <= step_temperature;
            idx   <= '0;
            total <= 32'd0;
            found <= 1'b0;
            fdiv  <= 1'b0;
            el0   <= now_seconds - start_time;
            e     <= now_seconds - start_time;
            run_rec <= active_recipe;
            if ({30'd0, recipe_index} < 32'(RECIPES)) begin
              if (opcode == rsp_pkg::OP_START_NOW) run_rec <= recipe_index;
              if ((opcode == rsp_pkg::OP_START_AT || opcode == rsp_pkg::OP_START_BY) &&
                  (ph == rsp_pkg::PH_IDLE || ph == rsp_pkg::PH_WAITING))
                run_rec <= recipe_index;
            end
          end
        end
        rsp_pkg::ST_EV: begin
          total <= total + d_rd;
          idx   <= idx + 1'b1;
          if (32'(idx) == 32'(stp_q)) wold <= d_rd;
          if (!found) begin
            if (idx == '0) begin
              if (e <= d_rd) begin
                found <= 1'b1;
                tf    <= t_rd;
              end else begin
                pd <= d_rd;
                pt <= t_rd;
              end
            end else if (es < d_rd) begin
              found <= 1'b1;
              fdiv  <= 1'b1;
              de    <= es;
              dd    <= d_rd;
              t0    <= pt;
              t1    <= t_rd;
            end else begin
              e  <= es;
              pd <= d_rd;
              pt <= t_rd;
            end
          end
        end
        rsp_pkg::ST_APPLY: begin
          sp_en <= (op == rsp_pkg::OP_TICK) && (ph == rsp_pkg::PH_COOKING);
          if (wr_en) mem_vld[wr_addr] <= 1'b1;
          case (op)
            rsp_pkg::OP_TICK: begin
              if (ph == rsp_pkg::PH_WAITING) begin
                if (now_q >= start_time) begin
                  start_time <= now_q;
                  ph         <= rsp_pkg::PH_COOKING;
                end
              end else if (ph == rsp_pkg::PH_COOKING) begin
                if (el0 >= total) ph <= rsp_pkg::PH_FINISHED;
              end
            end
            rsp_pkg::OP_START_NOW: begin
              if (rec_ok) begin
                active_recipe <= rec_q;
                start_time    <= now_q;
                ph            <= rsp_pkg::PH_COOKING;
              end
            end
            rsp_pkg::OP_START_AT: begin
              if (rec_ok && can_arm) begin
                active_recipe <= rec_q;
                start_time    <= tgt_q;
                ph            <= rsp_pkg::PH_WAITING;
              end
            end
            rsp_pkg::OP_START_BY: begin
              if (rec_ok && can_arm) begin
                active_recipe <= rec_q;
                start_time    <= tgt_q - total;
                ph            <= rsp_pkg::PH_WAITING;
              end
            end
            rsp_pkg::OP_NEXT: begin
              if (ph == rsp_pkg::PH_FINISHED) begin
                ph <= rsp_pkg::PH_IDLE;
              end else if (ph == rsp_pkg::PH_WAITING) begin
                start_time <= now_q;
                ph         <= rsp_pkg::PH_COOKING;
              end
            end
            rsp_pkg::OP_ABORT: ph <= rsp_pkg::PH_IDLE;
            rsp_pkg::OP_WRITE: begin
              if (wr_en && rec_q == run_rec) total <= total - wold + dur_q;
            end
            default: ;
          endcase
        end
        rsp_pkg::ST_MUL: begin
          num  <= MW'(mag) * MW'(de);
          rem  <= 32'd0;
          dcnt <= '0;
        end
        rsp_pkg::ST_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (rem_sh >= {1'b0, dd}) begin
            rem <= 32'(rem_sh - {1'b0, dd});
            num <= {num[rsp_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            num <= {num[rsp_pkg::NUM_W-2:0], 1'b0};
          end
        end
        rsp_pkg::ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            setpoint     <= sp_en ? ramp_val : 12'd0;
            released     <= ph == rsp_pkg::PH_COOKING;
            phase        <= ph;
            if (ph == rsp_pkg::PH_COOKING)
              remaining_seconds <= ((now_q - start_time) >= total) ? 32'd0
                                   : total - (now_q - start_time);
            else if (ph == rsp_pkg::PH_WAITING)
              remaining_seconds <= (start_time > now_q) ? start_time - now_q : 32'd0;
            else
              remaining_seconds <= 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rsp_checker.sv =====
// Port-level checks for the ramp-and-soak profile sequencer, bound to the top level.
// Depends on rsp_pkg and ramp_soak_profile_sequencer.
module rsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [11:0] setpoint,
  input logic        released,
  input logic [1:0]  phase,
  input logic [31:0] remaining_seconds
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(setpoint) && $stable(phase))
    else $error("result changed while stalled");

  a_released: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> released == (phase == rsp_pkg::PH_COOKING))
    else $error("released does not match phase");

  a_remaining: assert property (@(posedge clk) disable iff (rst)
    result_valid && (phase == rsp_pkg::PH_IDLE || phase == rsp_pkg::PH_FINISHED)
      |-> remaining_seconds == 32'd0)
    else $error("remaining time outside waiting or cooking");

  a_setpoint: assert property (@(posedge clk) disable iff (rst)
    result_valid && (phase == rsp_pkg::PH_IDLE || phase == rsp_pkg::PH_WAITING)
      |-> setpoint == 12'd0)
    else $error("setpoint given outside a cooking tick");

endmodule

bind ramp_soak_profile_sequencer rsp_checker u_rsp_checker (
  .clk(clk), .rst(rst), .result_valid(result_valid), .result_ready(result_ready),
  .setpoint(setpoint), .released(released), .phase(phase),
  .remaining_seconds(remaining_seconds)
);
